[design/kscb_pkg.sv]
// Shared constants, types and the scan code to ASCII table for the keyboard buffer.
package kscb_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int CHAR_W = 7;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [7:0] CODE_CTRL_PRESS   = 8'h1D;
  localparam logic [7:0] CODE_CTRL_RELEASE = 8'h9D;
  localparam logic [7:0] CODE_KEY_C        = 8'h2E;
  localparam logic [7:0] CODE_KEY_D        = 8'h20;
  localparam logic [CHAR_W-1:0] EOF_MARK   = '0;

  // Flags that travel with a word from the lookup stage to the result register.
  typedef struct packed {
    logic hit;
    logic irq;
    logic wake;
  } stage_flags_t;

  // Set-1 make code to ASCII; zero marks a key that produces no character.
  function automatic logic [CHAR_W-1:0] key_map(input logic [6:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      7'h01: ch = 7'h1B;
      7'h02: ch = 7'h31;
      7'h03: ch = 7'h32;
      7'h04: ch = 7'h33;
      7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;
      7'h07: ch = 7'h36;
      7'h08: ch = 7'h37;
      7'h09: ch = 7'h38;
      7'h0A: ch = 7'h39;
      7'h0B: ch = 7'h30;
      7'h0C: ch = 7'h2D;
      7'h0D: ch = 7'h3D;
      7'h0E: ch = 7'h08;
      7'h0F: ch = 7'h09;
      7'h10: ch = 7'h71;
      7'h11: ch = 7'h77;
      7'h12: ch = 7'h65;
      7'h13: ch = 7'h72;
      7'h14: ch = 7'h74;
      7'h15: ch = 7'h79;
      7'h16: ch = 7'h75;
      7'h17: ch = 7'h69;
      7'h18: ch = 7'h6F;
      7'h19: ch = 7'h70;
      7'h1A: ch = 7'h5B;
      7'h1B: ch = 7'h5D;
      7'h1C: ch = 7'h0A;
      7'h1E: ch = 7'h61;
      7'h1F: ch = 7'h73;
      7'h20: ch = 7'h64;
      7'h21: ch = 7'h66;
      7'h22: ch = 7'h67;
      7'h23: ch = 7'h68;
      7'h24: ch = 7'h6A;
      7'h25: ch = 7'h6B;
      7'h26: ch = 7'h6C;
      7'h27: ch = 7'h3B;
      7'h28: ch = 7'h27;
      7'h29: ch = 7'h60;
      7'h2B: ch = 7'h7C;
      7'h2C: ch = 7'h7A;
      7'h2D: ch = 7'h78;
      7'h2E: ch = 7'h63;
      7'h2F: ch = 7'h76;
      7'h30: ch = 7'h62;
      7'h31: ch = 7'h6E;
      7'h32: ch = 7'h6D;
      7'h33: ch = 7'h2C;
      7'h34: ch = 7'h2E;
      7'h35: ch = 7'h2F;
      7'h37: ch = 7'h2A;
      7'h39: ch = 7'h20;
      7'h4A: ch = 7'h2D;
      7'h4E: ch = 7'h2B;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

[design/kscb_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module kscb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/keyboard_scan_code_buffer_core.sv]
// Top level of the keyboard scan code buffer: Ctrl tracking, ASCII mapping and character store.
// Takes one word per cycle while item_stall is low and returns one result word per input word.
// The accepting edge issues the store read into its registered read port and registers the flags;
// the result register then loads when that stage advances, which result_stall can delay.
// A key event updates the Ctrl flag and the fill count and writes the store on the edge
// that accepts it, so a read accepted in the next cycle already sees that character. Store
// contents are not cleared at reset; only slots below the fill count are ever read back.
module keyboard_scan_code_buffer_core import kscb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              command,
  input  logic [7:0]        key_code,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [CHAR_W-1:0] char_out,
  output logic              char_valid,
  output logic              is_eof,
  output logic              interrupt_event,
  output logic              wake_reader
);

  logic [CNT_W-1:0]  fill_count, fill_count_next;
  logic [CNT_W-1:0]  read_position, read_position_next;
  logic              ctrl_held, ctrl_held_next;
  logic              s1_valid;
  stage_flags_t      s1_flags, s1_flags_next;

  logic              accept, s1_advance;
  logic              we, re;
  logic [IDX_W-1:0]  waddr;
  logic [CHAR_W-1:0] wdata, rdata, key_char;
  logic              room, drained;

  assign s1_advance = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_advance;
  assign accept     = item_valid && !item_stall;

  assign key_char = key_map(key_code[6:0]);
  assign room     = fill_count < CNT_W'(BUFFER_DEPTH);
  assign drained  = read_position == fill_count;

  always_comb begin
    fill_count_next    = fill_count;
    read_position_next = read_position;
    ctrl_held_next     = ctrl_held;
    s1_flags_next      = '0;
    we                 = 1'b0;
    waddr              = fill_count[IDX_W-1:0];
    wdata              = key_char;
    re                 = 1'b0;
    if (accept) begin
      if (command == CMD_READ) begin
        if (read_position < fill_count) begin
          re                 = 1'b1;
          s1_flags_next.hit  = 1'b1;
          read_position_next = read_position + CNT_W'(1);
        end
      end else if (key_code == CODE_CTRL_PRESS) begin
        ctrl_held_next = 1'b1;
      end else if (key_code == CODE_CTRL_RELEASE) begin
        ctrl_held_next = 1'b0;
      end else if (!key_code[7]) begin
        ctrl_held_next = 1'b0;
        if (key_code == CODE_KEY_C && ctrl_held) begin
          s1_flags_next.irq = 1'b1;
        end else if (key_code == CODE_KEY_D && ctrl_held) begin
          if (room) begin
            we                 = 1'b1;
            wdata              = EOF_MARK;
            fill_count_next    = fill_count + CNT_W'(1);
            s1_flags_next.wake = 1'b1;
          end
        end else if (key_char != '0) begin
          if (room) begin
            we                 = 1'b1;
            fill_count_next    = fill_count + CNT_W'(1);
            s1_flags_next.wake = 1'b1;
          end else if (drained) begin
            // Buffer full and fully read: start over at the first slot.
            we                 = 1'b1;
            waddr              = '0;
            fill_count_next    = CNT_W'(1);
            read_position_next = '0;
            s1_flags_next.wake = 1'b1;
          end
        end
      end
    end
  end

  kscb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (read_position[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      read_position <= '0;
      ctrl_held     <= 1'b0;
      s1_valid      <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      fill_count    <= fill_count_next;
      read_position <= read_position_next;
      ctrl_held     <= ctrl_held_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags <= s1_flags_next;
    end
    if (s1_advance) begin
      char_out        <= s1_flags.hit ? rdata : '0;
      char_valid      <= s1_flags.hit;
      is_eof          <= s1_flags.hit && (rdata == EOF_MARK);
      interrupt_event <= s1_flags.irq;
      wake_reader     <= s1_flags.wake;
    end
  end

endmodule

[design/kscb_checker.sv]
// Port-level assertions for the keyboard scan code buffer and their bind.
module kscb_checker import kscb_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input logic [CHAR_W-1:0] char_out,
  input logic              char_valid,
  input logic              is_eof,
  input logic              interrupt_event,
  input logic              wake_reader
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(char_out)
      && $stable(char_valid) && $stable(is_eof))
    else $error("stalled result word changed");

  a_read_no_key_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid && char_valid |-> !interrupt_event && !wake_reader)
    else $error("read result carries key event flags");

  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_eof |-> char_valid && char_out == EOF_MARK)
    else $error("end-of-file word is malformed");

  a_no_char_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !char_valid |-> char_out == '0 && !is_eof)
    else $error("character shown without a buffered entry");

  a_irq_no_wake: assert property (@(posedge clk) disable iff (rst)
    result_valid && interrupt_event |-> !wake_reader)
    else $error("interrupt and store on the same key event");

endmodule

bind keyboard_scan_code_buffer_core kscb_checker u_kscb_checker (
  .clk             (clk),
  .rst             (rst),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .char_out        (char_out),
  .char_valid      (char_valid),
  .is_eof          (is_eof),
  .interrupt_event (interrupt_event),
  .wake_reader     (wake_reader)
);

[sim/keyboard_scan_code_buffer_core_test.sv]
// Self-checking testbench for the keyboard scan code buffer core.
module keyboard_scan_code_buffer_core_test;
  import kscb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 1000;
  localparam logic [7:0] CODE_CAPS = 8'h3A;

  typedef struct packed {
    logic       cmd;
    logic [7:0] code;
    logic       wait_drain;
  } key_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              valid;
    logic              eof;
    logic              irq;
    logic              wake;
  } char_result_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic              command = CMD_KEY;
  logic [7:0]        key_code = 8'h00;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [CHAR_W-1:0] char_out;
  logic              char_valid;
  logic              is_eof;
  logic              interrupt_event;
  logic              wake_reader;

  key_word_t    typed_words[$];
  char_result_t pending_results[$];
  int           word_total = 0;
  int           accepted_cnt = 0;
  int           checked_cnt = 0;
  int           errors = 0;
  int           gap_left = 0;
  int           stall_left = 0;
  int           pace_left = 0;
  int           idle_cycles = 0;
  logic         calm = 1'b0;

  // Shadow of the buffer state, updated as each word is accepted.
  logic [CHAR_W-1:0] key_ascii [128];
  logic [CHAR_W-1:0] shadow_store [BUFFER_DEPTH];
  int                shadow_fill = 0;
  int                shadow_rd = 0;
  logic              shadow_ctrl = 1'b0;

  keyboard_scan_code_buffer_core u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .command(command),
    .key_code(key_code),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .char_out(char_out),
    .char_valid(char_valid),
    .is_eof(is_eof),
    .interrupt_event(interrupt_event),
    .wake_reader(wake_reader)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic map_run(input int first, input string keys);
    for (int i = 0; i < keys.len(); i++) key_ascii[first + i] = 7'(keys[i]);
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [7:0] any_mapped();
    logic [7:0] c;
    c = 8'($urandom_range(1, 127));
    while (key_ascii[c[6:0]] == 0) c = 8'($urandom_range(1, 127));
    return c;
  endfunction

  // Applies one word to the shadow state and returns the result it must produce.
  function automatic char_result_t apply_key_word(logic cmd, logic [7:0] code);
    char_result_t r;
    logic [CHAR_W-1:0] ch;
    logic had_ctrl;
    r = '0;
    if (cmd == CMD_READ) begin
      if (shadow_rd < shadow_fill) begin
        r.ch = shadow_store[shadow_rd];
        r.valid = 1'b1;
        r.eof = (shadow_store[shadow_rd] == EOF_MARK);
        shadow_rd++;
      end
    end else if (code == CODE_CTRL_PRESS) begin
      shadow_ctrl = 1'b1;
    end else if (code == CODE_CTRL_RELEASE) begin
      shadow_ctrl = 1'b0;
    end else if (!code[7]) begin
      had_ctrl = shadow_ctrl;
      shadow_ctrl = 1'b0;
      ch = key_ascii[code[6:0]];
      if (had_ctrl && code == CODE_KEY_C) begin
        r.irq = 1'b1;
      end else if (had_ctrl && code == CODE_KEY_D) begin
        if (shadow_fill < BUFFER_DEPTH) begin
          shadow_store[shadow_fill] = EOF_MARK;
          shadow_fill++;
          r.wake = 1'b1;
        end
      end else if (ch != 0) begin
        if (shadow_fill < BUFFER_DEPTH) begin
          shadow_store[shadow_fill] = ch;
          shadow_fill++;
          r.wake = 1'b1;
        end else if (shadow_rd == shadow_fill) begin
          // Full and fully read: writing starts over at the first slot.
          shadow_store[0] = ch;
          shadow_fill = 1;
          shadow_rd = 0;
          r.wake = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic add_word(input logic cmd, input logic [7:0] code, input logic hold);
    key_word_t w;
    w.cmd = cmd;
    w.code = code;
    w.wait_drain = hold;
    typed_words.push_back(w);
    word_total++;
  endtask

  task automatic add_reads(input int n);
    repeat (n) add_word(CMD_READ, 8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Fills the buffer past its end, then drains it and makes it start over.
  task automatic fill_and_wrap();
    repeat (66 + $urandom_range(0, 6)) add_word(CMD_KEY, any_mapped(), 1'b0);
    add_word(CMD_KEY, CODE_CTRL_PRESS, 1'b0);
    add_word(CMD_KEY, CODE_KEY_D, 1'b0);
    add_word(CMD_KEY, any_mapped(), 1'b0);
    if ($urandom_range(0, 1) == 1) begin
      add_reads($urandom_range(1, 10));
      add_word(CMD_KEY, any_mapped(), 1'b0);
    end
    add_reads(BUFFER_DEPTH + $urandom_range(0, 6));
    add_word(CMD_KEY, ($urandom_range(0, 1) == 1) ? CODE_CAPS : 8'h00, 1'b0);
    add_word(CMD_KEY, any_mapped(), 1'b0);
    add_reads(2);
  endtask

  task automatic typing_burst();
    int r;
    logic [7:0] c;
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        c = any_mapped();
        add_word(CMD_KEY, c, 1'b0);
        if ($urandom_range(0, 2) == 0) add_word(CMD_KEY, c | 8'h80, 1'b0);
      end else if (r < 80) begin
        add_word(CMD_KEY, CODE_CTRL_PRESS, 1'b0);
        case ($urandom_range(0, 5))
          0, 1: add_word(CMD_KEY, CODE_KEY_C, 1'b0);
          2, 3: add_word(CMD_KEY, CODE_KEY_D, 1'b0);
          4: add_word(CMD_KEY, CODE_CTRL_RELEASE, 1'b0);
          default: add_word(CMD_KEY, 8'($urandom_range(128, 255)), 1'b0);
        endcase
      end else if (r < 90) begin
        add_word(CMD_KEY, 8'($urandom_range(0, 255)), 1'b0);
      end else begin
        add_reads(1);
      end
    end
  endtask

  initial begin
    int mode;
    for (int i = 0; i < 128; i++) key_ascii[i] = '0;
    key_ascii[8'h01] = 7'h1B;
    map_run(8'h02, "1234567890-=");
    key_ascii[8'h0E] = 7'h08;
    key_ascii[8'h0F] = 7'h09;
    map_run(8'h10, "qwertyuiop[]");
    key_ascii[8'h1C] = 7'h0A;
    map_run(8'h1E, "asdfghjkl;'");
    key_ascii[8'h29] = 7'h60;
    map_run(8'h2B, "|zxcvbnm,./");
    key_ascii[8'h37] = 7'h2A;
    key_ascii[8'h39] = 7'h20;
    key_ascii[8'h4A] = 7'h2D;
    key_ascii[8'h4E] = 7'h2B;
    for (int i = 0; i < BUFFER_DEPTH; i++) shadow_store[i] = '0;

    // Directed words: empty reads, table edges, release codes, Ctrl combinations.
    add_word(CMD_READ, 8'hFF, 1'b0);
    add_word(CMD_KEY, 8'h00, 1'b0);
    add_word(CMD_KEY, 8'h7F, 1'b0);
    add_word(CMD_KEY, 8'h01, 1'b0);
    add_word(CMD_KEY, 8'h2B, 1'b0);
    add_word(CMD_KEY, 8'h4A, 1'b0);
    add_word(CMD_KEY, 8'h4E, 1'b0);
    add_word(CMD_KEY, 8'h80, 1'b0);
    add_word(CMD_KEY, 8'hFF, 1'b0);
    add_word(CMD_KEY, CODE_CTRL_PRESS, 1'b0);
    add_word(CMD_KEY, CODE_KEY_C, 1'b0);
    add_word(CMD_KEY, CODE_KEY_C, 1'b0);
    add_word(CMD_KEY, CODE_CTRL_PRESS, 1'b0);
    add_word(CMD_KEY, 8'hAE, 1'b0);
    add_word(CMD_KEY, CODE_KEY_D, 1'b0);
    add_word(CMD_KEY, CODE_CTRL_PRESS, 1'b0);
    add_word(CMD_KEY, CODE_CTRL_RELEASE, 1'b0);
    add_word(CMD_KEY, CODE_KEY_D, 1'b0);
    add_word(CMD_KEY, CODE_CTRL_PRESS, 1'b0);
    add_word(CMD_KEY, CODE_KEY_C, 1'b0);
    add_word(CMD_READ, 8'h00, 1'b1);
    add_reads(8);

    fill_and_wrap();
    while (word_total < 520) begin
      mode = $urandom_range(0, 99);
      if (mode < 40) typing_burst();
      else if (mode < 70) add_reads($urandom_range(1, 12));
      else if (mode < 78) fill_and_wrap();
      else if (mode < 84) add_word(CMD_KEY, any_mapped(), 1'b1);
      else repeat ($urandom_range(1, 4))
        add_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (accepted_cnt != word_total || pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Alternates stretches of free flow with stretches of random gaps and stalls.
  always @(posedge clk) begin
    if (pace_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      pace_left <= $urandom_range(20, 150);
    end else begin
      pace_left <= pace_left - 1;
    end
  end

  always @(posedge clk) begin : drive_words
    logic taken;
    logic drained;
    char_result_t want;
    taken = item_valid && !item_stall;
    drained = !taken && (accepted_cnt == checked_cnt);
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (taken) begin
        want = apply_key_word(command, key_code);
        pending_results.push_back(want);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!item_valid || taken) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          item_valid <= 1'b0;
        end else if (typed_words.size() != 0 && (!typed_words[0].wait_drain || drained)) begin
          item_valid <= 1'b1;
          command <= typed_words[0].cmd;
          key_code <= typed_words[0].code;
          void'(typed_words.pop_front());
          gap_left <= calm ? 0 : rand_gap();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input int want, input logic [CHAR_W-1:0] got);
    if (got !== want[CHAR_W-1:0]) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    char_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no word outstanding, expected none, got char %0h",
                   $time, char_out);
          errors++;
        end else begin
          want = pending_results.pop_front();
          checked_cnt <= checked_cnt + 1;
          compare_field("char_out", int'(want.ch), char_out);
          compare_field("char_valid", int'(want.valid), 7'(char_valid));
          compare_field("is_eof", int'(want.eof), 7'(is_eof));
          compare_field("interrupt_event", int'(want.irq), 7'(interrupt_event));
          compare_field("wake_reader", int'(want.wake), 7'(wake_reader));
        end
      end
      if (stall_left != 0) begin
        result_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        stall_left <= rand_gap();
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
